@@ rtl/ball_presence_photo_detector_macros.svh @@
// assertion macros shared by the ball presence detector rtl
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef BALL_PRESENCE_PHOTO_DETECTOR_MACROS_SVH
`define BALL_PRESENCE_PHOTO_DETECTOR_MACROS_SVH

// same-cycle implication
`define BPPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bppd_pkg.sv @@
// shared types and constants of the ball presence detector
// no dependencies
`default_nettype none

package bppd_pkg;

  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned ALPHA_W    = 16;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned PCT_SCALE  = 100;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [PCT_W-1:0]   PCT_RESET      = 7'd50;
  localparam int unsigned        BASE_MIN_RESET = 100;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET    = 16'd655;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THR_PCT  = 2'd0,
    CFG_BASE_MIN = 2'd1,
    CFG_ALPHA    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_CALIB = 1'b0,
    OP_RUN   = 1'b1
  } op_e;

  typedef struct packed {
    logic adv0;
    logic adv1;
    logic adv2;
  } pipe_adv_t;

endpackage

`default_nettype wire

@@ rtl/bppd_if.sv @@
// channel interfaces: sample requests, result requests, register writes
// depends on bppd_pkg
`default_nettype none

interface bppd_smp_if #(parameter int unsigned SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [SAMPLE_BITS-1:0] photo_sample;
  logic                   current_captured;

  modport source (output valid, op, photo_sample, current_captured, input ready);
  modport sink (input valid, op, photo_sample, current_captured, output ready);
endinterface

interface bppd_res_if #(parameter int unsigned SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic                   calib_done;
  logic                   sensor_fault;
  logic [SAMPLE_BITS-1:0] threshold;
  logic [SAMPLE_BITS-1:0] filtered_level;
  logic                   captured;

  modport source (output valid, calib_done, sensor_fault, threshold, filtered_level, captured,
                  input ready);
  modport sink (input valid, calib_done, sensor_fault, threshold, filtered_level, captured,
                output ready);
endinterface

interface bppd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bppd_pkg::CFG_IDX_W-1:0]   index;
  logic [bppd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/bppd_cfg.sv @@
// configuration registers: threshold percent, baseline minimum, filter alpha
// depends on bppd_pkg and bppd_if
`default_nettype none

module bppd_cfg #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bppd_cfg_if.sink                       cfg_i,
  output logic [bppd_pkg::PCT_W-1:0]     thr_pct_o,
  output logic [SAMPLE_BITS-1:0]         base_min_o,
  output logic [bppd_pkg::ALPHA_W-1:0]   alpha_o
);

  logic [bppd_pkg::PCT_W-1:0]   thr_pct_q;
  logic [SAMPLE_BITS-1:0]       base_min_q;
  logic [bppd_pkg::ALPHA_W-1:0] alpha_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_pct_q  <= bppd_pkg::PCT_RESET;
      base_min_q <= SAMPLE_BITS'(bppd_pkg::BASE_MIN_RESET);
      alpha_q    <= bppd_pkg::ALPHA_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bppd_pkg::CFG_THR_PCT:  thr_pct_q  <= cfg_i.data[bppd_pkg::PCT_W-1:0];
        bppd_pkg::CFG_BASE_MIN: base_min_q <= cfg_i.data[SAMPLE_BITS-1:0];
        bppd_pkg::CFG_ALPHA:    alpha_q    <= cfg_i.data[bppd_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  assign thr_pct_o  = thr_pct_q;
  assign base_min_o = base_min_q;
  assign alpha_o    = alpha_q;

endmodule

`default_nettype wire

@@ rtl/bppd_calib.sv @@
// calibration: sample accumulation, baseline by reciprocal multiply,
// threshold scaling over pipeline stages 0..2; depends on bppd_pkg
`default_nettype none

module bppd_calib #(
  parameter int unsigned CALIB_SAMPLES = 300,
  parameter int unsigned SAMPLE_BITS   = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bppd_pkg::pipe_adv_t          adv_i,
  input  logic                         op_i,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  input  logic [bppd_pkg::PCT_W-1:0]   thr_pct_i,
  input  logic [SAMPLE_BITS-1:0]       base_min_i,
  output logic                         done_o,
  output logic                         fault_o,
  output logic [SAMPLE_BITS-1:0]       thr_o,
  output logic [SAMPLE_BITS-1:0]       thr_cur_o
);

  localparam int unsigned SUM_W    = $clog2(CALIB_SAMPLES * ((2 ** SAMPLE_BITS) - 1) + 1);
  localparam int unsigned CNT_W    = $clog2(CALIB_SAMPLES + 1);
  localparam int unsigned DIV_SH   = SUM_W + $clog2(CALIB_SAMPLES);
  localparam logic [63:0] RECIP    =
      ((64'd1 << DIV_SH) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
  localparam int unsigned RECIP_W  = SUM_W + 1;
  localparam int unsigned P1_W     = SUM_W + RECIP_W;
  localparam int unsigned P2_W     = SAMPLE_BITS + bppd_pkg::PCT_W;
  localparam int unsigned SH2      = P2_W + $clog2(bppd_pkg::PCT_SCALE);
  localparam logic [63:0] RECIP2   =
      ((64'd1 << SH2) + 64'(bppd_pkg::PCT_SCALE) - 64'd1) / 64'(bppd_pkg::PCT_SCALE);
  localparam int unsigned RECIP2_W = P2_W + 1;
  localparam int unsigned P3_W     = P2_W + RECIP2_W;
  localparam logic [SAMPLE_BITS-1:0] THR_MAX = '1;

  logic [SUM_W-1:0]       sum_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   cal_q;
  logic                   fin1_q;
  logic                   fin2_q;
  logic                   flt2_q;
  logic                   fault_q;
  logic [SAMPLE_BITS-1:0] thr_q;
  logic [P1_W-1:0]        p1_q;
  logic [P2_W-1:0]        p2_q;

  logic                   is_cal;
  logic                   cnt_full;
  logic                   add0;
  logic                   fin0;
  logic [P1_W-1:0]        p1_d;
  logic [P1_W-1:0]        p1_sh;
  logic [SAMPLE_BITS-1:0] baseline;
  logic                   flt1;
  logic [P2_W-1:0]        p2_d;
  logic [P3_W-1:0]        p3;
  logic [P3_W-1:0]        p3_sh;
  logic [P2_W-1:0]        quot;
  logic [SAMPLE_BITS-1:0] thr_sat;

  // stage 0: accumulate or mark the finishing request
  assign is_cal   = (op_i == bppd_pkg::OP_CALIB);
  assign cnt_full = (cnt_q == CNT_W'(CALIB_SAMPLES));
  assign add0     = is_cal && !cal_q && !cnt_full;
  assign fin0     = is_cal && !cal_q && cnt_full;
  assign p1_d     = {{RECIP_W{1'b0}}, sum_q} * {{SUM_W{1'b0}}, RECIP[RECIP_W-1:0]};

  // stage 1: baseline and percent product
  assign p1_sh    = p1_q >> DIV_SH;
  assign baseline = p1_sh[SAMPLE_BITS-1:0];
  assign flt1     = (baseline < base_min_i);
  assign p2_d     = P2_W'(baseline) * P2_W'(thr_pct_i);

  // stage 2: divide by the percent scale, saturate
  assign p3      = P3_W'(p2_q) * P3_W'(RECIP2[RECIP2_W-1:0]);
  assign p3_sh   = p3 >> SH2;
  assign quot    = p3_sh[P2_W-1:0];
  assign thr_sat = (quot > P2_W'(THR_MAX)) ? THR_MAX : quot[SAMPLE_BITS-1:0];

  assign done_o    = fin2_q;
  assign fault_o   = fault_q | (fin2_q & flt2_q);
  assign thr_o     = fin2_q ? (flt2_q ? '0 : thr_sat) : thr_q;
  assign thr_cur_o = thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      cnt_q   <= '0;
      cal_q   <= 1'b0;
      fin1_q  <= 1'b0;
      fin2_q  <= 1'b0;
      fault_q <= 1'b0;
      thr_q   <= '0;
    end else begin
      if (adv_i.adv0) begin
        fin1_q <= fin0;
        if (add0) begin
          sum_q <= sum_q + SUM_W'(sample_i);
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (fin0) begin
          cal_q <= 1'b1;
        end
      end
      if (adv_i.adv1) begin
        fin2_q <= fin1_q;
      end
      if (adv_i.adv2) begin
        fault_q <= fault_o;
        thr_q   <= thr_o;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.adv0) begin
      p1_q <= p1_d;
    end
    if (adv_i.adv1) begin
      p2_q   <= p2_d;
      flt2_q <= flt1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bppd_filter.sv @@
// first-order low-pass filter of the photo level in q16 fixed point
// depends on bppd_pkg
`default_nettype none

module bppd_filter #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bppd_pkg::pipe_adv_t          adv_i,
  input  logic                         op_i,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  input  logic [bppd_pkg::ALPHA_W-1:0] alpha_i,
  output logic [SAMPLE_BITS-1:0]       level_o
);

  localparam int unsigned FV_W   = SAMPLE_BITS + bppd_pkg::FRAC_W;
  localparam int unsigned DIFF_W = FV_W + 1;
  localparam int unsigned PROD_W = DIFF_W + bppd_pkg::ALPHA_W + 1;

  logic [FV_W-1:0]          filter_q;
  logic                     seeded_q;
  logic                     run;
  logic [FV_W-1:0]          x;
  logic [FV_W-1:0]          y;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] step;
  logic [FV_W-1:0]          filter_d;

  // y + floor(alpha * (x - y) / 2^16), seeded with the first sample
  assign run      = (op_i == bppd_pkg::OP_RUN);
  assign x        = {sample_i, {bppd_pkg::FRAC_W{1'b0}}};
  assign y        = seeded_q ? filter_q : x;
  assign diff     = $signed({1'b0, x}) - $signed({1'b0, y});
  assign prod     = diff * $signed({1'b0, alpha_i});
  assign step     = prod >>> bppd_pkg::FRAC_W;
  assign filter_d = y + step[FV_W-1:0];

  assign level_o = run ? filter_d[FV_W-1 -: SAMPLE_BITS] : filter_q[FV_W-1 -: SAMPLE_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= '0;
      seeded_q <= 1'b0;
    end else if (adv_i.adv0 && run) begin
      filter_q <= filter_d;
      seeded_q <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ball_presence_photo_detector.sv @@
// Ball presence detector top level: input stage, pipeline, capture latch,
// result register. Depends on bppd_pkg, bppd_if, bppd_cfg, bppd_calib, bppd_filter.
//
// Usage:
//   smp_i carries sample requests: op (calibration or run), photo_sample and
//   current_captured. res_o returns exactly one result request per sample
//   request, in order. cfg_i writes the threshold percent, baseline minimum
//   and filter alpha; it is always ready and takes effect at once.
//   Every sample request passes an input register, two pipeline stages and a
//   result register. One request is taken every cycle while smp_i.ready
//   is high (throughput one per cycle).
//   The filter multiply lives in stage 0, the baseline reciprocal multiply
//   spans stages 0 and 1, and the percent scaling and capture latch stage 2.
//   Calibration completes on the first calibration request after
//   CALIB_SAMPLES accumulated ones; later calibration requests are ignored.
//   Reset clears calibration, filter and latch and loads register defaults.
//   When the receiver stalls, each stage keeps taking requests until it is
//   full, so smp_i.ready falls only when all four registers hold requests.
`default_nettype none

module ball_presence_photo_detector #(
  parameter int unsigned CALIB_SAMPLES = 300,
  parameter int unsigned SAMPLE_BITS   = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bppd_smp_if.sink     smp_i,
  bppd_res_if.source   res_o,
  bppd_cfg_if.sink     cfg_i
);

`include "ball_presence_photo_detector_macros.svh"

  logic [bppd_pkg::PCT_W-1:0]   thr_pct;
  logic [SAMPLE_BITS-1:0]       base_min;
  logic [bppd_pkg::ALPHA_W-1:0] alpha;

  logic                   s0_v_q;
  logic                   s0_op_q;
  logic [SAMPLE_BITS-1:0] s0_sample_q;
  logic                   s0_cur_q;
  logic                   s1_v_q;
  logic                   s1_op_q;
  logic                   s1_cur_q;
  logic [SAMPLE_BITS-1:0] s1_level_q;
  logic                   s2_v_q;
  logic                   s2_op_q;
  logic                   s2_cur_q;
  logic [SAMPLE_BITS-1:0] s2_level_q;
  logic                   out_v_q;
  logic                   out_done_q;
  logic                   out_fault_q;
  logic [SAMPLE_BITS-1:0] out_thr_q;
  logic [SAMPLE_BITS-1:0] out_level_q;
  logic                   out_capt_q;
  logic                   latch_q;
  logic                   latch_d;

  logic                   rdy_out;
  logic                   rdy2;
  logic                   rdy1;
  logic                   rdy0;
  bppd_pkg::pipe_adv_t    adv;

  logic                   cal_done;
  logic                   cal_fault;
  logic [SAMPLE_BITS-1:0] cal_thr;
  logic [SAMPLE_BITS-1:0] thr_cur;
  logic [SAMPLE_BITS-1:0] s0_level;

  // per-stage ready chain
  assign rdy_out  = !out_v_q || res_o.ready;
  assign rdy2     = !s2_v_q || rdy_out;
  assign rdy1     = !s1_v_q || rdy2;
  assign rdy0     = !s0_v_q || rdy1;
  assign adv.adv0 = s0_v_q && rdy1;
  assign adv.adv1 = s1_v_q && rdy2;
  assign adv.adv2 = s2_v_q && rdy_out;

  assign smp_i.ready = rdy0;

  bppd_cfg #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .thr_pct_o  (thr_pct),
    .base_min_o (base_min),
    .alpha_o    (alpha)
  );

  bppd_calib #(
    .CALIB_SAMPLES (CALIB_SAMPLES),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_calib (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .op_i       (s0_op_q),
    .sample_i   (s0_sample_q),
    .thr_pct_i  (thr_pct),
    .base_min_i (base_min),
    .done_o     (cal_done),
    .fault_o    (cal_fault),
    .thr_o      (cal_thr),
    .thr_cur_o  (thr_cur)
  );

  bppd_filter #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .op_i     (s0_op_q),
    .sample_i (s0_sample_q),
    .alpha_i  (alpha),
    .level_o  (s0_level)
  );

  // capture latch, stage 2
  always_comb begin
    latch_d = latch_q;
    if (s2_op_q == bppd_pkg::OP_RUN) begin
      if (s2_level_q >= thr_cur) begin
        latch_d = 1'b0;
      end else if (s2_cur_q) begin
        latch_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      latch_q <= 1'b0;
    end else begin
      if (rdy0) begin
        s0_v_q <= smp_i.valid;
      end
      if (rdy1) begin
        s1_v_q <= s0_v_q;
      end
      if (rdy2) begin
        s2_v_q <= s1_v_q;
      end
      if (rdy_out) begin
        out_v_q <= s2_v_q;
      end
      if (adv.adv2) begin
        latch_q <= latch_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && smp_i.valid) begin
      s0_op_q     <= smp_i.op;
      s0_sample_q <= smp_i.photo_sample;
      s0_cur_q    <= smp_i.current_captured;
    end
    if (adv.adv0) begin
      s1_op_q    <= s0_op_q;
      s1_cur_q   <= s0_cur_q;
      s1_level_q <= s0_level;
    end
    if (adv.adv1) begin
      s2_op_q    <= s1_op_q;
      s2_cur_q   <= s1_cur_q;
      s2_level_q <= s1_level_q;
    end
    if (adv.adv2) begin
      out_done_q  <= cal_done;
      out_fault_q <= cal_fault;
      out_thr_q   <= cal_thr;
      out_level_q <= s2_level_q;
      out_capt_q  <= latch_d;
    end
  end

  assign res_o.valid          = out_v_q;
  assign res_o.calib_done     = out_done_q;
  assign res_o.sensor_fault   = out_fault_q;
  assign res_o.threshold      = out_thr_q;
  assign res_o.filtered_level = out_level_q;
  assign res_o.captured       = out_capt_q;

  `BPPD_ASSERT_NEXT(a_accept_lands, smp_i.valid && smp_i.ready, s0_v_q, "accepted request lost")
  `BPPD_ASSERT_SAME(a_latch_needs_thr, latch_q, thr_cur != '0, "latch set without threshold")
  `BPPD_ASSERT_NEXT(a_s2_holds, s2_v_q && !rdy_out, s2_v_q, "stalled stage 2 request dropped")

endmodule

`default_nettype wire
